// ===== hdl/gev_pkg.sv =====
// ---------------------------------------------------------------------------
// Gamepad event generator package
// Shared widths, register indexes, event codes and the event record that
// passes from the sequencer to the output stage.
// ---------------------------------------------------------------------------
package gev_pkg;

   localparam int NUM_KEYS   = 24;
   localparam int NUM_AXES   = 6;
   localparam int KEY_W      = 5;
   localparam int AXIS_IDX_W = 3;
   localparam int AXIS_W     = 16;
   localparam int VALUE_W    = 17;
   localparam int KIND_W     = 2;
   localparam int LEVEL_W    = 15;
   localparam int BTN_W      = 14;
   localparam int STAMP_W    = 32;
   localparam int DELAY_W    = 32;

   localparam int DEFAULT_TIME_BITS = 32;

   // Configuration port.
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_DEAD_ZONE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_DEAD_ZONE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_THRESHOLD  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_REPEAT_DELAY = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_INTERVAL    = 3'd4;

   localparam logic [LEVEL_W-1:0] RESET_LEFT_DEAD_ZONE     = 15'd7849;
   localparam logic [LEVEL_W-1:0] RESET_RIGHT_DEAD_ZONE    = 15'd8689;
   localparam logic [LEVEL_W-1:0] RESET_TRIGGER_THRESHOLD  = 15'd3854;
   localparam logic [DELAY_W-1:0] RESET_FIRST_REPEAT_DELAY = 32'd200000;
   localparam logic [DELAY_W-1:0] RESET_REPEAT_INTERVAL    = 32'd100000;

   // Event kinds.
   localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REPEAT  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ANALOG  = 2'd3;

   // Axis reports use key numbers from this base upward.
   localparam logic [KEY_W-1:0] AXIS_KEY_BASE = 5'd24;

   // Request tdata layout, lowest field first.
   localparam int REQ_BTN_LO   = 0;
   localparam int REQ_LX_LO    = REQ_BTN_LO + BTN_W;
   localparam int REQ_LY_LO    = REQ_LX_LO + AXIS_W;
   localparam int REQ_RX_LO    = REQ_LY_LO + AXIS_W;
   localparam int REQ_RY_LO    = REQ_RX_LO + AXIS_W;
   localparam int REQ_LT_LO    = REQ_RY_LO + AXIS_W;
   localparam int REQ_RT_LO    = REQ_LT_LO + LEVEL_W;
   localparam int REQ_STAMP_LO = REQ_RT_LO + LEVEL_W;
   localparam int REQ_FIELDS_W = REQ_STAMP_LO + STAMP_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;

   // Response tdata layout: key, then value, then zero fill.
   localparam int RSP_FIELDS_W = KEY_W + VALUE_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [KEY_W-1:0]          key;
      logic signed [VALUE_W-1:0] value;
   } gev_evt_type;

   // Sequencer to output stage: push offers an event, close ends the item.
   typedef struct packed {
      logic        push;
      logic        close;
      gev_evt_type evt;
   } gev_push_type;

endpackage

// ===== hdl/gev_out_stage.sv =====
// ---------------------------------------------------------------------------
// Gamepad event output stage
// Holds one event back until the next one (or the end of the item) is known,
// so that tlast can be set on the final event, then registers it onto the
// result channel.
// ---------------------------------------------------------------------------
module gev_out_stage
   import gev_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  gev_push_type          ctl,
   output logic                  ok,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // key, analog_value, zero fill
   output logic [KIND_W-1:0]     rsp_tuser,   // event_kind
   output logic                  rsp_tlast
);

   logic        pend_valid_ff, pend_valid_in;
   gev_evt_type pend_ff, pend_in;
   logic        out_valid_ff, out_valid_in;
   gev_evt_type out_ff, out_in;
   logic        out_last_ff, out_last_in;
   logic        out_free;
   logic        move;

   assign out_free = !out_valid_ff || rsp_tready;
   assign ok       = !pend_valid_ff || out_free;
   assign move     = pend_valid_ff && out_free && (ctl.push || ctl.close);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      if (move) begin
         out_in       = pend_ff;
         out_last_in  = ctl.close;
         out_valid_in = 1'b1;
      end
      if (ctl.push && ok) begin
         pend_in       = ctl.evt;
         pend_valid_in = 1'b1;
      end else if (ctl.close && ok) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_ff.value, out_ff.key};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== hdl/gamepad_event_generator.sv =====
// ---------------------------------------------------------------------------
// Gamepad event generator
// Turns controller samples into analog reports and press, release and
// auto-repeat key events; a flush command releases everything.
// ---------------------------------------------------------------------------
// One transaction is taken at a time. After acceptance a sample runs six axis
// steps, twenty-four key steps and one closing step; a flush runs twenty-four
// key steps, then six axis steps and the closing step. Each step of a sample
// goes through the single shared subtractor (an axis magnitude against its
// threshold, or the time stamp against a key's repeat deadline), and a
// step that emits an event waits while the result channel is back-pressured.
// The final event of a transaction carries tlast; a transaction that causes
// no event produces nothing on the result channel.
module gamepad_event_generator
   import gev_pkg::*;
#(
   parameter int TIME_BITS = DEFAULT_TIME_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // buttons, left_x, left_y, right_x, right_y, left_trigger, right_trigger,
   // now_time, zero fill
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tuser,   // command
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // key, analog_value, zero fill
   output logic [KIND_W-1:0]      rsp_tuser,   // event_kind
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ALU_W = (TIME_BITS > VALUE_W) ? TIME_BITS : VALUE_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_AXIS  = 3'd1;
   localparam logic [2:0] ST_KEY   = 3'd2;
   localparam logic [2:0] ST_FKEY  = 3'd3;
   localparam logic [2:0] ST_FAXIS = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam logic [KEY_W-1:0] LAST_KEY  = KEY_W'(NUM_KEYS - 1);
   localparam logic [KEY_W-1:0] LAST_AXIS = KEY_W'(NUM_AXES - 1);

   // Configuration registers.
   logic [LEVEL_W-1:0] left_dz_ff, right_dz_ff, trig_thr_ff;
   logic [DELAY_W-1:0] first_delay_ff, interval_ff;

   // Sequencer and state.
   logic [2:0]          state_ff, state_in;
   logic [KEY_W-1:0]    idx_ff, idx_in;
   logic [NUM_KEYS-1:0] held_ff, held_in;
   logic [AXIS_W-1:0]   prev_ff [NUM_AXES];
   logic [AXIS_W-1:0]   prev_in;
   logic                prev_we;
   logic [TIME_BITS-1:0] deadline_ff [NUM_KEYS];
   logic [TIME_BITS-1:0] deadline_in;
   logic                 deadline_we;

   // Latched sample.
   logic [AXIS_W-1:0]    axis_ff [NUM_AXES];
   logic [TIME_BITS-1:0] now_ff;
   logic [NUM_KEYS-1:0]  cur_ff, cur_in;

   logic [AXIS_IDX_W-1:0] aidx;
   logic                  accept;
   logic                  stage_ok;
   logic                  emit;
   logic                  go;
   gev_push_type          push;

   // Shared subtractor.
   logic [ALU_W-1:0] alu_a, alu_b;
   logic [ALU_W:0]   alu_diff;
   logic             alu_borrow;
   logic             due;

   // Axis datapath.
   logic signed [AXIS_W-1:0]  raw;
   logic                      raw_neg;
   logic signed [VALUE_W-1:0] raw_ext;
   logic [VALUE_W-1:0]        mag;
   logic [VALUE_W-1:0]        pos_scaled;
   logic signed [VALUE_W-1:0] nv_base, nv;
   logic [LEVEL_W-1:0]        thr_sel;
   logic [KEY_W-1:0]          dir_neg_key, dir_pos_key;

   // Key step.
   logic key_c, key_p, do_press, do_release, do_repeat;

   assign aidx       = idx_ff[AXIS_IDX_W-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Axis value, magnitude and Q1.15 scaling. A positive v maps to
   // round(v * 32768 / 32767), which is v plus one exactly when v >= 16384.
   always_comb begin
      raw        = axis_ff[aidx];
      raw_neg    = raw[AXIS_W-1];
      raw_ext    = {raw[AXIS_W-1], raw};
      mag        = raw_neg ? VALUE_W'(-raw_ext) : VALUE_W'(raw_ext);
      pos_scaled = {1'b0, raw} + VALUE_W'(raw[AXIS_W-2]);
      nv_base    = raw_neg ? raw_ext : pos_scaled;
      nv         = (aidx == 3'd1 || aidx == 3'd3) ? -nv_base : nv_base;
      case (aidx)
         3'd0, 3'd1: thr_sel = left_dz_ff;
         3'd2, 3'd3: thr_sel = right_dz_ff;
         default:    thr_sel = trig_thr_ff;
      endcase
      case (aidx)
         3'd0:    begin dir_neg_key = 5'd18; dir_pos_key = 5'd19; end
         3'd1:    begin dir_neg_key = 5'd16; dir_pos_key = 5'd17; end
         3'd2:    begin dir_neg_key = 5'd22; dir_pos_key = 5'd23; end
         3'd3:    begin dir_neg_key = 5'd20; dir_pos_key = 5'd21; end
         3'd4:    begin dir_neg_key = 5'd10; dir_pos_key = 5'd10; end
         default: begin dir_neg_key = 5'd11; dir_pos_key = 5'd11; end
      endcase
   end

   // The subtractor compares a magnitude with its threshold in axis steps and
   // takes the wrapping distance to a deadline in key steps.
   always_comb begin
      if (state_ff == ST_KEY) begin
         alu_a = ALU_W'(now_ff);
         alu_b = ALU_W'(deadline_ff[idx_ff]);
      end else begin
         alu_a = ALU_W'(thr_sel);
         alu_b = ALU_W'(mag);
      end
      alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
      alu_borrow = alu_diff[ALU_W];
      due        = !alu_diff[TIME_BITS-1];
   end

   always_comb begin
      key_c      = cur_ff[idx_ff];
      key_p      = held_ff[idx_ff];
      do_press   = key_c && !key_p;
      do_release = !key_c && key_p;
      do_repeat  = key_c && key_p && due;
   end

   always_comb begin
      emit       = 1'b0;
      push.close = 1'b0;
      push.evt   = '{kind: KIND_PRESS, key: idx_ff, value: '0};
      case (state_ff)
         ST_AXIS: begin
            emit           = (prev_ff[aidx] != raw) || alu_borrow;
            push.evt.kind  = KIND_ANALOG;
            push.evt.key   = AXIS_KEY_BASE + idx_ff;
            push.evt.value = nv;
         end
         ST_KEY: begin
            emit = do_press || do_release || do_repeat;
            if (do_release) begin
               push.evt.kind = KIND_RELEASE;
            end else if (do_repeat) begin
               push.evt.kind = KIND_REPEAT;
            end
         end
         ST_FKEY: begin
            emit          = key_p;
            push.evt.kind = KIND_RELEASE;
         end
         ST_FAXIS: begin
            emit          = (prev_ff[aidx] != '0);
            push.evt.kind = KIND_ANALOG;
            push.evt.key  = AXIS_KEY_BASE + idx_ff;
         end
         ST_DONE: begin
            push.close = 1'b1;
         end
         default: begin
         end
      endcase
      push.push = emit;
      go        = !(emit || push.close) || stage_ok;
   end

   // Sequencer next state.
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      held_in     = held_ff;
      cur_in      = cur_ff;
      prev_in     = raw;
      prev_we     = 1'b0;
      deadline_we = 1'b0;
      deadline_in = now_ff + (do_press ? TIME_BITS'(first_delay_ff) : TIME_BITS'(interval_ff));
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = req_tuser ? ST_FKEY : ST_AXIS;
               idx_in   = '0;
            end
         end
         ST_AXIS: begin
            if (go) begin
               prev_we = 1'b1;
               if (alu_borrow) begin
                  cur_in[raw_neg ? dir_neg_key : dir_pos_key] = 1'b1;
               end
               if (idx_ff == LAST_AXIS) begin
                  state_in = ST_KEY;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         ST_KEY: begin
            if (go) begin
               held_in[idx_ff] = key_c;
               deadline_we     = do_press || do_repeat;
               if (idx_ff == LAST_KEY) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         ST_FKEY: begin
            if (go) begin
               held_in[idx_ff] = 1'b0;
               if (idx_ff == LAST_KEY) begin
                  state_in = ST_FAXIS;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         ST_FAXIS: begin
            if (go) begin
               prev_we = 1'b1;
               prev_in = '0;
               if (idx_ff == LAST_AXIS) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         ST_DONE: begin
            if (go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         idx_ff         <= '0;
         held_ff        <= '0;
         left_dz_ff     <= RESET_LEFT_DEAD_ZONE;
         right_dz_ff    <= RESET_RIGHT_DEAD_ZONE;
         trig_thr_ff    <= RESET_TRIGGER_THRESHOLD;
         first_delay_ff <= RESET_FIRST_REPEAT_DELAY;
         interval_ff    <= RESET_REPEAT_INTERVAL;
         for (int i = 0; i < NUM_AXES; i++) begin
            prev_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         held_ff  <= held_in;
         if (prev_we) begin
            prev_ff[aidx] <= prev_in;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_LEFT_DEAD_ZONE:     left_dz_ff     <= csr_wdata[LEVEL_W-1:0];
               CSR_RIGHT_DEAD_ZONE:    right_dz_ff    <= csr_wdata[LEVEL_W-1:0];
               CSR_TRIGGER_THRESHOLD:  trig_thr_ff    <= csr_wdata[LEVEL_W-1:0];
               CSR_FIRST_REPEAT_DELAY: first_delay_ff <= csr_wdata[DELAY_W-1:0];
               CSR_REPEAT_INTERVAL:    interval_ff    <= csr_wdata[DELAY_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Sample payload and repeat deadlines. A deadline is only read for a held
   // key, and every press writes it first, so it needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         axis_ff[0] <= req_tdata[REQ_LX_LO +: AXIS_W];
         axis_ff[1] <= req_tdata[REQ_LY_LO +: AXIS_W];
         axis_ff[2] <= req_tdata[REQ_RX_LO +: AXIS_W];
         axis_ff[3] <= req_tdata[REQ_RY_LO +: AXIS_W];
         axis_ff[4] <= {1'b0, req_tdata[REQ_LT_LO +: LEVEL_W]};
         axis_ff[5] <= {1'b0, req_tdata[REQ_RT_LO +: LEVEL_W]};
         now_ff     <= TIME_BITS'(req_tdata[REQ_STAMP_LO +: STAMP_W]);
         cur_ff     <= {8'd0, req_tdata[REQ_BTN_LO + 10 +: 4], 2'd0,
                        req_tdata[REQ_BTN_LO +: 10]};
      end else begin
         cur_ff <= cur_in;
      end
      if (deadline_we) begin
         deadline_ff[idx_ff] <= deadline_in;
      end
   end

   gev_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .ctl        (push),
      .ok         (stage_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_key_index_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_KEY || state_ff == ST_FKEY) |-> (idx_ff <= LAST_KEY))
      else $error("key step index out of range");

   a_axis_index_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AXIS || state_ff == ST_FAXIS) |-> (idx_ff <= LAST_AXIS))
      else $error("axis step index out of range");

   a_flush_clears_keys: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FAXIS) |-> (held_ff == '0))
      else $error("held key survived the flush key pass");

   a_idle_after_close: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && stage_ok) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after closing");

endmodule
